>>> src/four_level_page_table_insert_core_assert.svh
// Assertion helpers for the page table insert core.
// Both forms sample on clk and stay quiet while rst_n is low.
`ifndef FOUR_LEVEL_PAGE_TABLE_INSERT_CORE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_INSERT_CORE_ASSERT_SVH

`ifndef SYNTH
`define FPTI_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FPTI_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);
`else
`define FPTI_ASSERT(label, cond, msg)
`define FPTI_ASSERT_NEXT(label, trig, cond, msg)
`endif

`endif

>>> src/fpti_pkg.sv
`default_nettype none
package fpti_pkg;

  // Geometry of one table level.
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned ENTRY_W          = 64;
  // Physical page number: address bits 51..12.
  localparam int unsigned PPN_W            = 40;
  // Virtual page number: address bits 47..12.
  localparam int unsigned VPN_W            = 36;

  localparam int unsigned TABLE_PAGES_DEF  = 64;

  // table_base resets to 4096, i.e. page number 1.
  localparam logic [PPN_W-1:0] BASE_PPN_RESET = 40'd1;

  // Entry bit positions.
  localparam int unsigned BIT_PRESENT   = 0;
  localparam int unsigned BIT_PS        = 7;

  // Result status codes.
  localparam logic [1:0] STAT_ADDED    = 2'd0;
  localparam logic [1:0] STAT_PRESENT  = 2'd1;
  localparam logic [1:0] STAT_CONFLICT = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // Page size codes.
  localparam logic [1:0] PSIZE_4K      = 2'd2;
  localparam logic [1:0] PSIZE_BAD     = 2'd3;

  // One word of the table store. The phase bit tells whether the entry was
  // written after its page was handed out; a stale phase reads as zero.
  typedef struct packed {
    logic               phase;
    logic [ENTRY_W-1:0] data;
  } store_word_t;

endpackage
`default_nettype wire

>>> src/four_level_page_table_insert_core.sv
`default_nettype none
// Four-level page table insert engine.
//
// A request arrives as one transfer on the in_ channel: a virtual address,
// a physical address and a page size (1 GB, 2 MB or 4 KB). The engine walks
// the radix table held in an internal single-port store, allocates and
// links any missing intermediate tables, writes the leaf and returns one
// transfer on the out_ channel with a status, the number of table pages
// taken and the leaf entry. table_base is set through cfg_wr_en/cfg_wr_data;
// the user must write it only while the engine is idle; the block does not enforce it.
//
// Each table level takes a store read step and an evaluate step that may
// write back, and a request touches one to four levels; an invalid page
// size goes straight to the result. One request is in flight at a time,
// limited by the single store port and the dependent walk.
// After reset the store is swept to zero, one entry per cycle, over all
// TABLE_PAGES*512 entries (32768 at the default); in_tready stays low during
// the sweep. A stalled out_ channel holds its result and the engine waits
// with the next result until the output register is free.
module four_level_page_table_insert_core
  import fpti_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // [47:0] virtual_address, [99:48] physical_address, [101:100] map_size
  input  wire  [103:0] in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // [1:0] status, [3:2] pages_taken, [67:4] leaf_entry
  output logic [71:0]  out_tdata,
  input  wire          cfg_wr_en,
  input  wire  [51:0]  cfg_wr_data
);

`include "four_level_page_table_insert_core_assert.svh"

  localparam int unsigned PAGE_W = $clog2(TABLE_PAGES);
  localparam int unsigned NFP_W  = PAGE_W + 1;
  localparam int unsigned DEPTH  = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int unsigned ADDR_W = PAGE_W + IDX_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]          state_r,      state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r,   clr_addr_nxt;
  logic [PPN_W-1:0]    base_r,       base_nxt;
  logic [NFP_W-1:0]    nfp_r,        nfp_nxt;
  logic [VPN_W-1:0]    vpn_r,        vpn_nxt;
  logic [PPN_W-1:0]    pa_r,         pa_nxt;
  logic [1:0]          size_r,       size_nxt;
  logic [1:0]          lvl_r,        lvl_nxt;
  logic [PAGE_W-1:0]   page_r,       page_nxt;
  logic [1:0]          taken_r,      taken_nxt;
  logic [PPN_W-1:0]    alloc_pa_r,   alloc_pa_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [1:0]          res_taken_r,  res_taken_nxt;
  logic [ENTRY_W-1:0]  res_leaf_r,   res_leaf_nxt;
  logic                out_valid_r,  out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [1:0]          out_taken_r,  out_taken_nxt;
  logic [ENTRY_W-1:0]  out_leaf_r,   out_leaf_nxt;

  logic                mem_en;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  store_word_t         mem_wdata;
  store_word_t         mem_rdata;

  logic [IDX_W-1:0]    idx_cur;
  logic                page_live;
  logic [ENTRY_W-1:0]  ent;
  logic [PPN_W-1:0]    ptr_off;
  logic                ptr_ok;
  logic                leaf_step;
  logic                nfp_full;
  logic                leaf_match;
  logic [ENTRY_W-1:0]  want_entry;
  logic [ENTRY_W-1:0]  ptr_entry;

  fpti_table_ram #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Nine index bits per level, top level first.
  always_comb begin
    case (lvl_r)
      2'd0:    idx_cur = vpn_r[35:27];
      2'd1:    idx_cur = vpn_r[26:18];
      2'd2:    idx_cur = vpn_r[17:9];
      default: idx_cur = vpn_r[8:0];
    endcase
  end

  // A page at or above the allocation mark has not been handed out yet, so
  // anything written there before its allocation must read back as zero.
  assign page_live  = {1'b0, page_r} < nfp_r;
  assign ent        = (mem_rdata.phase == page_live) ? mem_rdata.data : '0;
  assign ptr_off    = ent[51:12] - base_r;
  assign ptr_ok     = ptr_off < PPN_W'(TABLE_PAGES);
  assign leaf_step  = {1'b0, lvl_r} == ({1'b0, size_r} + 3'd1);
  assign nfp_full   = nfp_r >= NFP_W'(TABLE_PAGES);
  assign leaf_match = (ent[51:12] == pa_r) &&
                      ((size_r == PSIZE_4K) || ent[BIT_PS]);
  // Only 1 GB and 2 MB leaves carry the page-size bit.
  assign want_entry = {12'h000, pa_r, 4'h0, (size_r != PSIZE_4K), 5'h00, 2'b11};
  assign ptr_entry  = {12'h000, alloc_pa_r, 10'h000, 2'b11};

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    base_nxt       = base_r;
    nfp_nxt        = nfp_r;
    vpn_nxt        = vpn_r;
    pa_nxt         = pa_r;
    size_nxt       = size_r;
    lvl_nxt        = lvl_r;
    page_nxt       = page_r;
    taken_nxt      = taken_r;
    alloc_pa_nxt   = alloc_pa_r;
    res_status_nxt = res_status_r;
    res_taken_nxt  = res_taken_r;
    res_leaf_nxt   = res_leaf_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_taken_nxt  = out_taken_r;
    out_leaf_nxt   = out_leaf_r;
    mem_en         = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = {page_r, idx_cur};
    mem_wdata      = '0;

    if (cfg_wr_en) begin
      base_nxt = cfg_wr_data[51:12];
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_addr_r;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          vpn_nxt   = in_tdata[47:12];
          pa_nxt    = in_tdata[99:60];
          size_nxt  = in_tdata[101:100];
          lvl_nxt   = 2'd0;
          page_nxt  = '0;
          taken_nxt = 2'd0;
          if (in_tdata[101:100] == PSIZE_BAD) begin
            res_status_nxt = STAT_CONFLICT;
            res_taken_nxt  = 2'd0;
            res_leaf_nxt   = '0;
            state_nxt      = ST_DONE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_en       = 1'b1;
        // Address of the page a missing entry would take.
        alloc_pa_nxt = base_r + PPN_W'(nfp_r);
        state_nxt    = ST_EVAL;
      end
      ST_EVAL: begin
        if (leaf_step) begin
          res_taken_nxt = taken_r;
          state_nxt     = ST_DONE;
          if (!ent[BIT_PRESENT]) begin
            mem_en          = 1'b1;
            mem_we          = 1'b1;
            mem_wdata.phase = page_live;
            mem_wdata.data  = want_entry;
            res_status_nxt  = STAT_ADDED;
            res_leaf_nxt    = want_entry;
          end else begin
            res_status_nxt = leaf_match ? STAT_PRESENT : STAT_CONFLICT;
            res_leaf_nxt   = ent;
          end
        end else if (!ent[BIT_PRESENT]) begin
          if (nfp_full) begin
            res_status_nxt = STAT_FULL;
            res_taken_nxt  = taken_r;
            res_leaf_nxt   = '0;
            state_nxt      = ST_DONE;
          end else begin
            // The new page is cleared by advancing the mark; the pointer is
            // written with the phase seen after that advance, so it stays
            // valid even when it lands in the page just taken.
            mem_en          = 1'b1;
            mem_we          = 1'b1;
            mem_wdata.phase = {1'b0, page_r} <= nfp_r;
            mem_wdata.data  = ptr_entry;
            page_nxt        = nfp_r[PAGE_W-1:0];
            nfp_nxt         = nfp_r + 1'b1;
            taken_nxt       = taken_r + 2'd1;
            lvl_nxt         = lvl_r + 2'd1;
            state_nxt       = ST_READ;
          end
        end else if (ent[BIT_PS] || !ptr_ok) begin
          // A large page on the way, or a pointer outside the store.
          res_status_nxt = STAT_CONFLICT;
          res_taken_nxt  = taken_r;
          res_leaf_nxt   = ent;
          state_nxt      = ST_DONE;
        end else begin
          page_nxt  = ptr_off[PAGE_W-1:0];
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_taken_nxt  = res_taken_r;
          out_leaf_nxt   = res_leaf_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      base_r      <= BASE_PPN_RESET;
      nfp_r       <= NFP_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      base_r      <= base_nxt;
      nfp_r       <= nfp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vpn_r        <= vpn_nxt;
    pa_r         <= pa_nxt;
    size_r       <= size_nxt;
    lvl_r        <= lvl_nxt;
    page_r       <= page_nxt;
    taken_r      <= taken_nxt;
    alloc_pa_r   <= alloc_pa_nxt;
    res_status_r <= res_status_nxt;
    res_taken_r  <= res_taken_nxt;
    res_leaf_r   <= res_leaf_nxt;
    out_status_r <= out_status_nxt;
    out_taken_r  <= out_taken_nxt;
    out_leaf_r   <= out_leaf_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_leaf_r, out_taken_r, out_status_r};

  `FPTI_ASSERT(a_no_accept_in_clear, !((state_r == ST_CLEAR) && in_tready), "request taken during store sweep")
  `FPTI_ASSERT(a_nfp_bounds, (nfp_r != '0) && (nfp_r <= NFP_W'(TABLE_PAGES)), "allocation mark out of range")
  `FPTI_ASSERT_NEXT(a_accept_starts_walk, in_tvalid && in_tready, state_r != ST_IDLE, "accepted request did not start")
  `FPTI_ASSERT(a_full_has_zero_leaf, !(out_valid_r && (out_status_r == STAT_FULL)) || (out_leaf_r == '0), "full status with nonzero leaf")

endmodule
`default_nettype wire

>>> src/fpti_table_ram.sv
`default_nettype none
module fpti_table_ram
  import fpti_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_PAGES_DEF * ENTRIES_PER_PAGE,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire               clk,
  input  wire               en,
  input  wire               we,
  input  wire  [ADDR_W-1:0] addr,
  input  store_word_t       wdata,
  output store_word_t       rdata
);

  store_word_t mem [DEPTH];

  // Single port with a registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/page_table_insert_check.sv
`timescale 1ns / 1ps
// Watches the request, result and table_base ports of the page table insert
// core, keeps a private copy of the table store, and compares every result
// transfer with the result predicted for the oldest outstanding request.
module page_table_insert_check
  import fpti_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [103:0] in_tdata,
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire  [71:0]  out_tdata,
  input  wire          cfg_wr_en,
  input  wire  [51:0]  cfg_wr_data,
  output int           fail_count,
  output int           outstanding,
  output int           added_total,
  output int           present_total,
  output int           conflict_total,
  output int           full_total
);

  // Present and writable, set in every entry this engine writes.
  localparam logic [11:0] ENTRY_FLAGS = 12'h003;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         taken;
    logic [ENTRY_W-1:0] leaf;
  } insert_result_t;

  logic [ENTRY_W-1:0] entry_mem [0:TABLE_PAGES*ENTRIES_PER_PAGE-1];
  int unsigned        free_page;
  logic [PPN_W-1:0]   base_ppn;
  insert_result_t     expected_q [$];
  int                 mismatch_tally;
  int                 result_index;
  int                 tally [4];

  function automatic insert_result_t insert_mapping(input logic [47:0] va,
                                                    input logic [51:0] pa,
                                                    input logic [1:0]  size);
    logic [IDX_W-1:0]   idx [4];
    int unsigned        leaf_level;
    int unsigned        page;
    int unsigned        slot;
    int unsigned        np;
    logic [ENTRY_W-1:0] e;
    logic [ENTRY_W-1:0] want;
    logic [PPN_W-1:0]   rel;
    insert_result_t     r;
    r = '{status: STAT_CONFLICT, taken: 2'd0, leaf: '0};
    if (size == PSIZE_BAD) return r;
    for (int lvl = 0; lvl < 4; lvl++) idx[lvl] = va[47 - 9*lvl -: 9];
    leaf_level = size + 1;
    page = 0;
    for (int lvl = 0; lvl < leaf_level; lvl++) begin
      slot = page * ENTRIES_PER_PAGE + idx[lvl];
      e = entry_mem[slot];
      if (!e[BIT_PRESENT]) begin
        if (free_page >= TABLE_PAGES) begin
          r.status = STAT_FULL;
          return r;
        end
        np = free_page;
        free_page++;
        for (int k = 0; k < ENTRIES_PER_PAGE; k++) entry_mem[np*ENTRIES_PER_PAGE + k] = '0;
        entry_mem[slot] = {12'h000, base_ppn + PPN_W'(np), ENTRY_FLAGS};
        page = np;
        r.taken = r.taken + 2'd1;
      end else if (e[BIT_PS]) begin
        r.leaf = e;
        return r;
      end else begin
        // Pointers are resolved relative to the current base, wrapping.
        rel = e[51:12] - base_ppn;
        if (rel >= TABLE_PAGES) begin
          r.leaf = e;
          return r;
        end
        page = 32'(rel);
      end
    end
    slot = page * ENTRIES_PER_PAGE + idx[leaf_level];
    e = entry_mem[slot];
    want = {12'h000, pa[51:12], ENTRY_FLAGS};
    if (size != PSIZE_4K) want[BIT_PS] = 1'b1;
    if (!e[BIT_PRESENT]) begin
      entry_mem[slot] = want;
      r.status = STAT_ADDED;
      r.leaf = want;
    end else begin
      if (e[51:12] == pa[51:12] && (size == PSIZE_4K || e[BIT_PS]))
        r.status = STAT_PRESENT;
      r.leaf = e;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at result %0d: %s is %h, expected %h", result_index, what, got, want);
    mismatch_tally++;
  endtask

  always @(posedge clk) begin
    insert_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_PAGES*ENTRIES_PER_PAGE; i++) entry_mem[i] = '0;
      free_page = 1;
      base_ppn = BASE_PPN_RESET;
      expected_q.delete();
      mismatch_tally = 0;
      result_index = 0;
      for (int s = 0; s < 4; s++) tally[s] = 0;
    end else begin
      if (cfg_wr_en) base_ppn = cfg_wr_data[51:12];
      // Results come back only after their request's transfer, so retire first.
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request outstanding", out_tdata[67:4], '0);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tdata[1:0] != exp_r.status)
            report_mismatch("status", 64'(out_tdata[1:0]), 64'(exp_r.status));
          if (out_tdata[3:2] != exp_r.taken)
            report_mismatch("pages_taken", 64'(out_tdata[3:2]), 64'(exp_r.taken));
          if (out_tdata[67:4] != exp_r.leaf)
            report_mismatch("leaf_entry", out_tdata[67:4], exp_r.leaf);
          tally[exp_r.status]++;
        end
        result_index++;
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(insert_mapping(in_tdata[47:0], in_tdata[99:48],
                                            in_tdata[101:100]));
    end
    outstanding    <= expected_q.size();
    fail_count     <= mismatch_tally;
    added_total    <= tally[STAT_ADDED];
    present_total  <= tally[STAT_PRESENT];
    conflict_total <= tally[STAT_CONFLICT];
    full_total     <= tally[STAT_FULL];
  end

endmodule

>>> tb/four_level_page_table_insert_core_test.sv
`timescale 1ns / 1ps
// Top of the page table insert testbench. It makes the clock, the single
// reset, the request stimulus, the receiver's ready pattern and the
// table_base writes. All prediction and comparison lives in the check module,
// which hands back its failure count and the number of outstanding requests.
module four_level_page_table_insert_core_test;
  import fpti_pkg::*;

  // Page size codes that the package does not name.
  localparam logic [1:0] PSIZE_1G = 2'd0;
  localparam logic [1:0] PSIZE_2M = 2'd1;

  // The post-reset sweep alone clears 32768 entries; a correct run of about 1200
  // requests with random stalls and one long hold-off ends far below this.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Wait well past the longest walk, one of four levels.
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int          IDLE_PERCENT = 34;
  localparam int          PHASE_ITEMS  = 170;
  // The receiver's long hold-off starts after this many result transfers.
  localparam int          HOLD_AT      = 420;
  localparam int          HOLD_CYCLES  = 500;
  localparam int          HISTORY_MAX  = 48;

  typedef struct packed {
    logic [47:0] va;
    logic [51:0] pa;
    logic [1:0]  size;
  } map_request_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  // [47:0] virtual_address, [99:48] physical_address, [101:100] map_size
  logic [103:0]  in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  // [1:0] status, [3:2] pages_taken, [67:4] leaf_entry
  logic [71:0]   out_tdata;
  logic          cfg_wr_en;
  logic [51:0]   cfg_wr_data;

  int            fail_count;
  int            outstanding;
  int            added_total;
  int            present_total;
  int            conflict_total;
  int            full_total;

  // While steady is set neither side idles.
  logic          steady;
  int            requests_sent;
  int            base_settings;
  map_request_t  history_q [$];

  four_level_page_table_insert_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  page_table_insert_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .added_total   (added_total),
    .present_total (present_total),
    .conflict_total(conflict_total),
    .full_total    (full_total)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offers one request, idling first at random, and returns at the edge of
  // its transfer. Ready is sampled right after the edge, before the core's
  // registers update, so it is the value that decided the transfer.
  task automatic send_request(input map_request_t req);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {2'b00, req.size, req.pa, req.va};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_map(input logic [47:0] va, input logic [51:0] pa,
                          input logic [1:0] size);
    map_request_t req;
    req = '{va: va, pa: pa, size: size};
    send_request(req);
  endtask

  // Stops offering, waits until every result has come back, and then lets
  // the engine finish any write-back before the next register write.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_base(input logic [51:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
    base_settings++;
  endtask

  // Table indices mostly come from a small set so that walks share tables
  // and requests revisit mapped slots; the rest are fully random.
  function automatic logic [8:0] pick_index();
    case ($urandom_range(9))
      0, 1, 2: return 9'd0;
      3:       return 9'd1;
      4:       return 9'd2;
      5:       return 9'd511;
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  function automatic logic [51:0] fresh_pa();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[51:0];
  endfunction

  function automatic map_request_t next_random_request();
    map_request_t req;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 50 && history_q.size() != 0) begin
      req = history_q[$urandom_range(history_q.size() - 1)];
      // Half of these, a quarter of all requests, are exact repeats; the rest change the target or the size.
      if (pick >= 25 && pick < 40) req.pa = fresh_pa();
      else if (pick >= 40) req.size = 2'($urandom_range(2));
      req.va[11:0] = 12'($urandom_range(4095));
    end else begin
      req.va   = {pick_index(), pick_index(), pick_index(), pick_index(),
                  12'($urandom_range(4095))};
      req.pa   = fresh_pa();
      req.size = (pick < 55) ? PSIZE_BAD : 2'($urandom_range(2));
    end
    if (req.size != PSIZE_BAD) begin
      history_q.push_back(req);
      if (history_q.size() > HISTORY_MAX) void'(history_q.pop_front());
    end
    return req;
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_request(next_random_request());
  endtask

  // The receiver: random ready, except while steady, and one long hold-off
  // that it counts out itself while the sender keeps offering requests, so
  // the output register fills and the core stops accepting.
  initial begin : receiver
    int  results_seen;
    bit  hold_done;
    results_seen = 0;
    hold_done    = 1'b0;
    out_tready   = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) results_seen++;
      if (!hold_done && results_seen >= HOLD_AT) begin
        out_tready <= 1'b0;
        for (int held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // A stuck handshake ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("four_level_page_table_insert_core_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] raw;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    steady        = 1'b0;
    requests_sent = 0;
    base_settings = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset base. The first request waits out the
    // clearing sweep on its handshake.
    // A 4 KB map into the empty table takes three pages; a repeat matches,
    // a new target conflicts, and larger sizes at the same address find a
    // pointer where their leaf would be.
    send_map(48'h0, 52'h0, PSIZE_4K);
    send_map(48'h0, 52'h0, PSIZE_4K);
    send_map(48'h0, 52'h5000, PSIZE_4K);
    send_map(48'h0, 52'h0, PSIZE_2M);
    send_map(48'h0, 52'h0, PSIZE_1G);
    // All-ones address and target as a 1 GB page, a repeat, then smaller pages
    // that run into that large page on their way down.
    send_map(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, PSIZE_1G);
    send_map(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, PSIZE_1G);
    send_map(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, PSIZE_2M);
    send_map(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, PSIZE_4K);
    // A 1 GB leaf at the same address with another target, which conflicts.
    send_map(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_C000_0000, PSIZE_1G);
    // 2 MB leaf beside the existing 4 KB table, then a repeat.
    send_map(48'h0000_0020_0000, 52'h0000_0020_0000, PSIZE_2M);
    send_map(48'h0000_0020_0ABC, 52'h0000_0020_0000, PSIZE_2M);
    // Low bits of both addresses are ignored.
    send_map(48'h0000_0000_1000, 52'h0000_1234_5ABC, PSIZE_4K);
    send_map(48'h0000_0000_1FFF, 52'h0000_1234_5FFF, PSIZE_4K);
    // Invalid page size, with all-ones and all-zero fields.
    send_map(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, PSIZE_BAD);
    send_map(48'h0, 52'h0, PSIZE_BAD);
    // New branches, the first below the top level and the rest at the top, take one, three, two and one pages.
    send_map(48'h0000_4000_0000, 52'hA_AAAA_AAAA_A000, PSIZE_2M);
    send_map(48'h0080_0000_0000, 52'h5_5555_5555_5000, PSIZE_4K);
    send_map(48'h0100_0000_0000, 52'h3_0000_0000_0000, PSIZE_2M);
    send_map(48'h0180_0000_0000, 52'h0_0000_4000_0000, PSIZE_1G);

    // Random phases, each under its own table_base. Moving the base makes
    // old pointers resolve to other pages or fall outside the store.
    run_random(PHASE_ITEMS);
    settle();
    write_table_base(52'h0);
    run_random(PHASE_ITEMS);
    settle();
    write_table_base(52'hF_FFFF_FFFF_FFFF);
    run_random(PHASE_ITEMS);
    settle();
    // Back to the reset base, with both sides running flat out.
    write_table_base(52'h0_0000_0000_1000);
    steady = 1'b1;
    run_random(PHASE_ITEMS);
    settle();
    steady = 1'b0;
    write_table_base(52'(($urandom_range(1, 70) + 1) * 4096 + $urandom_range(4095)));
    run_random(PHASE_ITEMS);
    settle();
    raw = {$urandom(), $urandom()};
    write_table_base(raw[51:0]);
    run_random(PHASE_ITEMS);
    settle();
    write_table_base(52'h0_0000_0000_1000);
    run_random(PHASE_ITEMS);
    settle();

    $display("Sent %0d map requests under %0d table_base settings.",
             requests_sent, base_settings);
    $display("Results: %0d added, %0d already present, %0d conflict, %0d out of pages.",
             added_total, present_total, conflict_total, full_total);
    if (fail_count == 0 && outstanding == 0) begin
      $display("four_level_page_table_insert_core_test OK");
    end else begin
      $display("four_level_page_table_insert_core_test NOT OK");
    end
    $finish;
  end

endmodule
